// ----- rtl/rwsr_pkg.sv -----
// Shared types and constants for the ring window sum/range block.
// No dependencies; compiled first.
package rwsr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 22;
    localparam int WLEN_W   = 7;
    localparam int LOOK_W   = 6;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam int MAX_WINDOW = 64;
    localparam logic [SAMPLE_W-1:0] MIN_SEED = 16'd32000;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;
    localparam logic [LOOK_W-1:0] LOOK_RESET = 6'd0;

    // register byte addresses
    localparam logic [ADDR_W-1:0] REG_WINDOW_LENGTH  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_LOOKBACK_STEPS = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic issue_look;
        logic issue_walk;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_last;
        logic win_empty;
    } t_stat;

endpackage

// ----- rtl/rwsr_if.sv -----
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on rwsr_pkg for field widths.
interface rwsr_in_if;
    logic                           valid;
    logic                           ready;
    logic [rwsr_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rwsr_out_if;
    logic                           valid;
    logic                           ready;
    logic [rwsr_pkg::SUM_W-1:0]     window_sum;
    logic [rwsr_pkg::SAMPLE_W-1:0]  window_range;
    logic [rwsr_pkg::SAMPLE_W-1:0]  past_sample;

    modport source (output valid, output window_sum, output window_range,
                    output past_sample, input ready);
    modport sink   (input valid, input window_sum, input window_range,
                    input past_sample, output ready);
endinterface

// ----- rtl/ring_window_sum_range_core.sv -----
// Moving sum and range over a ring of samples; top level with APB registers.
// Depends on rwsr_pkg, rwsr_if, rwsr_ctrl, rwsr_dp.
//
// Usage:
//   i_in  : one 16-bit sample per transfer (valid/ready).
//   o_out : one result per sample: sum of the newest window_length samples,
//           their max minus min (min seeded at 32000, floored at zero), and
//           the sample lookback_steps places back (zero is newest).
//   APB   : window_length at 0x0, lookback_steps at 0x4; write only while idle.
// Flow: one item at a time; the walk reads n window entries, with
//   n = window_length saturated to min(64, DEPTH), and a new sample is
//   taken only once the result for the one in work is loaded. The single
//   RAM read port walks one window entry per cycle.
// The next sample is taken as soon as a result is loaded, even if the
//   receiver has not yet taken it; a stalled receiver holds the result and
//   blocks the following result load until the transfer happens.
// Reset: ring reads as zero (a fill count masks unwritten entries, no
//   clearing pass), write slot to zero, registers to 16 and 0.
module ring_window_sum_range_core #(
    parameter int DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rwsr_in_if.sink                        i_in,
    rwsr_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rwsr_pkg::ADDR_W-1:0]    paddr,
    input  logic [rwsr_pkg::DATA_W-1:0]    pwdata,
    output logic [rwsr_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import rwsr_pkg::*;

    logic [WLEN_W-1:0] r_window_length;
    logic [LOOK_W-1:0] r_lookback_steps;
    logic              cfg_wr;
    t_cmd              cmd;
    t_stat             stat;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length  <= WLEN_RESET;
            r_lookback_steps <= LOOK_RESET;
        end else if (cfg_wr) begin
            case (paddr)
                REG_WINDOW_LENGTH:  r_window_length  <= pwdata[WLEN_W-1:0];
                REG_LOOKBACK_STEPS: r_lookback_steps <= pwdata[LOOK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_WINDOW_LENGTH:  prdata = DATA_W'(r_window_length);
            REG_LOOKBACK_STEPS: prdata = DATA_W'(r_lookback_steps);
            default:            prdata = '0;
        endcase
    end

    rwsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    rwsr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample         (i_in.sample),
        .i_window_length  (r_window_length),
        .i_lookback_steps (r_lookback_steps),
        .o_window_sum     (o_out.window_sum),
        .o_window_range   (o_out.window_range),
        .o_past_sample    (o_out.past_sample)
    );

endmodule

// ----- rtl/rwsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rwsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rwsr_ctrl.sv -----
// Sequencer for one item: write, lookback read, window walk, result load.
// Depends on rwsr_pkg for the command and status structs.
module rwsr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  rwsr_pkg::t_stat i_stat,
    output rwsr_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);
    import rwsr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_WALK = 5'b00100,
        S_LAST = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        cmd         = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.issue_look = 1'b1;
                n_state = i_stat.win_empty ? S_LAST : S_WALK;
            end
            S_WALK: begin
                cmd.issue_walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // last read data lands in the accumulators (for an empty window, in the past sample) here
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/rwsr_dp.sv -----
// Datapath: ring RAM, write slot, fill count, window walk and accumulators.
// Depends on rwsr_pkg and rwsr_ram.
module rwsr_dp #(
    parameter int DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rwsr_pkg::t_cmd                  i_cmd,
    output rwsr_pkg::t_stat                 o_stat,
    input  logic [rwsr_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [rwsr_pkg::WLEN_W-1:0]     i_window_length,
    input  logic [rwsr_pkg::LOOK_W-1:0]     i_lookback_steps,
    output logic [rwsr_pkg::SUM_W-1:0]      o_window_sum,
    output logic [rwsr_pkg::SAMPLE_W-1:0]   o_window_range,
    output logic [rwsr_pkg::SAMPLE_W-1:0]   o_past_sample
);
    import rwsr_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (CW > WLEN_W) ? CW : WLEN_W;
    localparam int MAXW  = (DEPTH < MAX_WINDOW) ? DEPTH : MAX_WINDOW;
    localparam int LOOKN = 2 ** LOOK_W;

    // lookback modulo DEPTH, resolved at elaboration
    logic [AW-1:0] mod_lut [LOOKN];
    for (genvar k = 0; k < LOOKN; k++) begin : g_mod
        assign mod_lut[k] = AW'(k % DEPTH);
    end

    logic [AW-1:0]       r_wr_slot;
    logic [AW-1:0]       r_newest;
    logic [CW-1:0]       r_fill;
    logic [WLEN_W-1:0]   r_n;
    logic [WLEN_W-1:0]   r_walk_cnt;
    logic [AW-1:0]       r_walk_addr;
    logic                r_rd_vld;
    logic                r_rd_look;
    logic                r_rd_ok;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_min;
    logic [SAMPLE_W-1:0] r_max;
    logic [SAMPLE_W-1:0] r_past;
    logic [SUM_W-1:0]    r_out_sum;
    logic [SAMPLE_W-1:0] r_out_range;
    logic [SAMPLE_W-1:0] r_out_past;

    logic [AW-1:0]       look_back;
    logic [AW-1:0]       look_addr;
    logic [AW-1:0]       rd_addr;
    logic                rd_ok;
    logic [SAMPLE_W-1:0] rd_data;
    logic [SAMPLE_W-1:0] x;
    logic [WLEN_W-1:0]   n_sat;
    logic [SAMPLE_W-1:0] range;

    assign look_back = mod_lut[i_lookback_steps];
    assign look_addr = (r_newest >= look_back) ? (r_newest - look_back)
                     : AW'((AW+1)'(r_newest) + (AW+1)'(DEPTH) - (AW+1)'(look_back));

    assign rd_addr = i_cmd.issue_look ? look_addr : r_walk_addr;
    // entries older than the fill count were never written and read as zero
    assign rd_ok   = i_cmd.issue_look ? (CMPW'(look_back) < CMPW'(r_fill))
                                      : (CMPW'(r_walk_cnt) < CMPW'(r_fill));

    assign n_sat = (i_window_length > WLEN_W'(MAXW)) ? WLEN_W'(MAXW) : i_window_length;

    rwsr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_wr_slot),
        .i_wdata (i_sample),
        .i_re    (i_cmd.issue_look | i_cmd.issue_walk),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign x     = r_rd_ok ? rd_data : '0;
    assign range = (r_max > r_min) ? (r_max - r_min) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_fill    <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue_look | i_cmd.issue_walk;
            if (i_cmd.accept) begin
                r_wr_slot <= (r_wr_slot == AW'(DEPTH - 1)) ? '0 : r_wr_slot + 1'b1;
                if (r_fill != CW'(DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_look <= i_cmd.issue_look;
        r_rd_ok   <= rd_ok;
        if (i_cmd.accept) begin
            r_newest    <= r_wr_slot;
            r_walk_addr <= r_wr_slot;
            r_walk_cnt  <= '0;
            r_n         <= n_sat;
            r_sum       <= '0;
            r_min       <= MIN_SEED;
            r_max       <= '0;
        end
        if (i_cmd.issue_walk) begin
            r_walk_cnt  <= r_walk_cnt + 1'b1;
            r_walk_addr <= (r_walk_addr == '0) ? AW'(DEPTH - 1) : r_walk_addr - 1'b1;
        end
        if (r_rd_vld && r_rd_look) begin
            r_past <= x;
        end
        if (r_rd_vld && !r_rd_look) begin
            r_sum <= r_sum + SUM_W'(x);
            if (x < r_min) begin
                r_min <= x;
            end
            if (x > r_max) begin
                r_max <= x;
            end
        end
        if (i_cmd.load_out) begin
            r_out_sum   <= r_sum;
            r_out_range <= range;
            r_out_past  <= r_past;
        end
    end

    assign o_stat.walk_last = (r_walk_cnt == r_n - 1'b1);
    assign o_stat.win_empty = (r_n == '0);

    assign o_window_sum   = r_out_sum;
    assign o_window_range = r_out_range;
    assign o_past_sample  = r_out_past;

endmodule

// ----- rtl/rwsr_chk.sv -----
// Port-level checker for ring_window_sum_range_core, attached by bind.
// Depends on rwsr_pkg for field widths.
module rwsr_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [rwsr_pkg::SUM_W-1:0]     i_window_sum,
    input logic [rwsr_pkg::SAMPLE_W-1:0]  i_window_range,
    input logic [rwsr_pkg::SAMPLE_W-1:0]  i_past_sample
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_window_sum) && $stable(i_window_range) && $stable(i_past_sample))
        else $error("result payload changed while stalled");

    // one item in flight: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second sample taken while one is in work");

    // a fresh result never appears the cycle right after an input transfer
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

endmodule

bind ring_window_sum_range_core rwsr_chk u_rwsr_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_window_sum   (o_out.window_sum),
    .i_window_range (o_out.window_range),
    .i_past_sample  (o_out.past_sample)
);
